// ===== design/wcg_pkg.sv =====
package wcg_pkg;

  // field widths
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned PHASE_W = 24;
  localparam int unsigned CFG_W   = 13;

  // divider: one quotient bit per cell, quotient may reach 2^24
  localparam int unsigned DIV_STEPS = PHASE_W + 1;

  // nested Taylor forms
  localparam int unsigned NEST_STEPS = 6;
  localparam int unsigned CELL_LAT   = 3;
  localparam int unsigned NEST_LAT   = NEST_STEPS * CELL_LAT;
  localparam int unsigned SIN_DIVS [NEST_STEPS] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_DIVS [NEST_STEPS] = '{132, 90, 56, 30, 12, 2};

  // Q30 constants
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [63:0] K054 = 64'sd579820585;
  localparam logic signed [63:0] K046 = 64'sd493921239;
  localparam logic signed [63:0] K042 = 64'sd450971566;
  localparam logic signed [63:0] K008 = 64'sd85899346;

  localparam logic [COEF_W-1:0] COEF_ONE = 16'd32768;

  typedef enum logic [1:0] {
    WIN_BARTLETT = 2'd0,
    WIN_HANN     = 2'd1,
    WIN_HAMMING  = 2'd2,
    WIN_BLACKMAN = 2'd3
  } win_t;

  typedef enum logic [1:0] {
    REG_TYPE = 2'd0,
    REG_SYM  = 2'd1,
    REG_SIZE = 2'd2
  } reg_idx_t;

  // how a word is finished
  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_UNIT   = 2'd2
  } kind_t;

  // side data that rides along the cosine cells
  typedef struct packed {
    logic [30:0]       th;
    logic [30:0]       th2;
    logic [1:0]        quad;
    logic [1:0]        quad2;
    logic [COEF_W-1:0] bart;
    kind_t             kind;
  } nest_side_t;

endpackage

// ===== design/wcg_in_if.sv =====
interface wcg_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

// ===== design/wcg_out_if.sv =====
interface wcg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] coefficient;
  logic        out_of_range;

  modport source (output valid, output coefficient, output out_of_range, input ready);
  modport sink   (input valid, input coefficient, input out_of_range, output ready);
endinterface

// ===== design/wcg_div_cell.sv =====
module wcg_div_cell
  import wcg_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [SIZE_W-1:0]     den,
  input  logic [SIZE_W-1:0]     rem_in,
  input  logic [DIV_STEPS-1:0]  w_in,
  output logic [SIZE_W-1:0]     rem,
  output logic [DIV_STEPS-1:0]  w
);

  logic [SIZE_W:0] rem_sh;
  logic            ge;

  // one restoring step: numerator bit leaves the top of w into the remainder, quotient bit enters at the bottom
  assign rem_sh = {rem_in, w_in[DIV_STEPS-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= ge ? SIZE_W'(rem_sh - {1'b0, den}) : rem_sh[SIZE_W-1:0];
      w   <= {w_in[DIV_STEPS-2:0], ge};
    end
  end

endmodule

// ===== design/wcg_nest_cell.sv =====
module wcg_nest_cell
  import wcg_pkg::*;
#(
  parameter int unsigned DIV = 2
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x2_in,
  input  logic [30:0] t_in,
  output logic [31:0] x2_out,
  output logic [30:0] t_out
);

  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(DIV));

  logic [62:0] prod_a;
  logic [63:0] prod_b;
  logic [31:0] m_a, m_b, q0_b, x2_a, x2_b;
  logic [39:0] rem_c;
  logic [32:0] q_c;
  logic signed [34:0] v_c;

  // stage 1: x2 * t, back to Q30
  assign prod_a = 63'(x2_in) * 63'(t_in);

  // stage 2: quotient estimate by reciprocal, low by at most one
  assign prod_b = 64'(m_a) * 64'(RECIP);

  // stage 3: correct, subtract from one, clamp to [0,1]
  assign rem_c = 40'(m_b) - 40'(q0_b) * 40'(DIV);
  assign q_c   = 33'(q0_b) + 33'(rem_c >= 40'(DIV));
  assign v_c   = $signed(35'(ONE_Q30)) - $signed({2'b00, q_c});

  always_ff @(posedge clk) begin
    if (en) begin
      m_a    <= prod_a[61:30];
      x2_a   <= x2_in;
      q0_b   <= prod_b[63:32];
      m_b    <= m_a;
      x2_b   <= x2_a;
      t_out  <= v_c[34] ? '0 : v_c[30:0];
      x2_out <= x2_b;
    end
  end

endmodule

// ===== design/window_coefficient_generator.sv =====
// Throughput: one index per cycle; the whole pipeline holds while the output stalls.
// Stages: input, the 25 divider cells (one phase bit each), angle, square,
// the six nested cosine cells of three stages each on every track, then sine,
// quadrant select, product and output.
// Reset (rst, synchronous): pipeline emptied; window_type Hann, symmetric, size 1024.
module window_coefficient_generator
  import wcg_pkg::*;
#(
  parameter int MAX_SIZE = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  wcg_in_if.sink            in_ch,
  wcg_out_if.source         out_ch
);

  localparam int unsigned LAT = 1 + DIV_STEPS + 2 + NEST_LAT + 4;

  // configuration registers
  win_t              window_type;
  logic              symmetric_mode;
  logic [SIZE_W-1:0] window_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_type    <= WIN_HANN;
      symmetric_mode <= 1'b1;
      window_size    <= 13'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TYPE: window_type    <= win_t'(cfg_data[1:0]);
        REG_SYM:  symmetric_mode <= cfg_data[0];
        REG_SIZE: window_size    <= cfg_data[SIZE_W-1:0];
        default:  ;
      endcase
    end
  end

  // effective size and denominator; the user must keep them static while items are in flight (not enforced here)
  logic [SIZE_W-1:0] size_eff, den;
  assign size_eff = (32'(window_size) > 32'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : window_size;
  assign den      = symmetric_mode ? size_eff - 1'b1 : size_eff;

  // pipeline advance and valid line
  logic           adv;
  logic [LAT-1:0] vld;
  assign adv         = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  // input stage: classify and form the numerator i*2^24 + den/2
  logic [36:0]          n_word;
  kind_t                kind_in;
  logic [SIZE_W-1:0]    s0_rem;
  logic [DIV_STEPS-1:0] s0_w;
  kind_t                s0_kind;

  assign n_word = 37'({in_ch.sample_index, 24'd0}) + 37'(den >> 1);

  always_comb begin
    if (13'(in_ch.sample_index) >= size_eff) begin
      kind_in = KIND_RANGE;
    end else if (den == '0) begin
      kind_in = KIND_UNIT;
    end else begin
      kind_in = KIND_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_rem  <= 13'(n_word[36:25]);
      s0_w    <= n_word[24:0];
      s0_kind <= kind_in;
    end
  end

  // divider chain
  logic [SIZE_W-1:0]    d_rem  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] d_w    [0:DIV_STEPS];
  kind_t                d_kind [0:DIV_STEPS];

  assign d_rem[0]  = s0_rem;
  assign d_w[0]    = s0_w;
  assign d_kind[0] = s0_kind;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    wcg_div_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .den    (den),
      .rem_in (d_rem[k]),
      .w_in   (d_w[k]),
      .rem    (d_rem[k+1]),
      .w      (d_w[k+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        d_kind[k+1] <= d_kind[k];
      end
    end
  end

  // angle stage: quadrant, angle in Q30, triangle value
  logic [PHASE_W-1:0] ph, ph2, tri_x;
  logic [52:0]        th_prod, th2_prod;
  logic [30:0]        t_th, t_th2;
  logic [1:0]         t_quad, t_quad2;
  logic [COEF_W-1:0]  t_bart;
  kind_t              t_kind;

  assign ph       = d_w[DIV_STEPS][PHASE_W-1:0];
  assign ph2      = {ph[PHASE_W-2:0], 1'b0};
  assign th_prod  = 53'(ph[21:0])  * 53'(HALF_PI_Q30);
  assign th2_prod = 53'(ph2[21:0]) * 53'(HALF_PI_Q30);
  assign tri_x    = ph[PHASE_W-1] ? PHASE_W'(25'h100_0000 - 25'(ph)) : ph;

  always_ff @(posedge clk) begin
    if (adv) begin
      t_th    <= th_prod[52:22];
      t_th2   <= th2_prod[52:22];
      t_quad  <= ph[23:22];
      t_quad2 <= ph2[23:22];
      t_bart  <= COEF_W'((25'(tri_x) + 25'd128) >> 8);
      t_kind  <= d_kind[DIV_STEPS];
    end
  end

  // square stage
  logic [61:0] sq_prod, sq2_prod;
  logic [31:0] x_x2, x_x2b;
  nest_side_t  side [0:NEST_LAT];

  assign sq_prod  = 62'(t_th)  * 62'(t_th);
  assign sq2_prod = 62'(t_th2) * 62'(t_th2);

  always_ff @(posedge clk) begin
    if (adv) begin
      x_x2    <= sq_prod[61:30];
      x_x2b   <= sq2_prod[61:30];
      side[0] <= '{th: t_th, th2: t_th2, quad: t_quad, quad2: t_quad2,
                   bart: t_bart, kind: t_kind};
    end
  end

  // cosine cells: track 0 sin p, 1 cos p, 2 sin 2p, 3 cos 2p
  logic [31:0] x2_s [0:3][0:NEST_STEPS];
  logic [30:0] t_s  [0:3][0:NEST_STEPS];

  for (genvar g = 0; g < 4; g++) begin : g_track
    assign x2_s[g][0] = (g < 2) ? x_x2 : x_x2b;
    assign t_s[g][0]  = ONE_Q30;

    for (genvar k = 0; k < NEST_STEPS; k++) begin : g_step
      wcg_nest_cell #(
        .DIV ((g % 2 == 1) ? COS_DIVS[k] : SIN_DIVS[k])
      ) u_cell (
        .clk    (clk),
        .en     (adv),
        .x2_in  (x2_s[g][k]),
        .t_in   (t_s[g][k]),
        .x2_out (x2_s[g][k+1]),
        .t_out  (t_s[g][k+1])
      );
    end
  end

  for (genvar k = 0; k < NEST_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        side[k+1] <= side[k];
      end
    end
  end

  // sine stage: s = th * ts
  nest_side_t  se;
  logic [61:0] s_prod, s2_prod;
  logic [31:0] s_s, s_s2;
  logic [30:0] s_c, s_c2;
  logic [1:0]  s_quad, s_quad2;
  logic [COEF_W-1:0] s_bart;
  kind_t       s_kind;

  assign se      = side[NEST_LAT];
  assign s_prod  = 62'(se.th)  * 62'(t_s[0][NEST_STEPS]);
  assign s2_prod = 62'(se.th2) * 62'(t_s[2][NEST_STEPS]);

  always_ff @(posedge clk) begin
    if (adv) begin
      s_s     <= s_prod[61:30];
      s_s2    <= s2_prod[61:30];
      s_c     <= t_s[1][NEST_STEPS];
      s_c2    <= t_s[3][NEST_STEPS];
      s_quad  <= se.quad;
      s_quad2 <= se.quad2;
      s_bart  <= se.bart;
      s_kind  <= se.kind;
    end
  end

  // quadrant selects cos, -sin, -cos or sin
  function automatic logic signed [31:0] cos_sel(input logic [1:0] q,
                                                  input logic [31:0] s,
                                                  input logic [30:0] c);
    logic signed [31:0] sv, cv;
    sv = $signed(s);
    cv = $signed({1'b0, c});
    case (q)
      2'd0:    cos_sel = cv;
      2'd1:    cos_sel = -sv;
      2'd2:    cos_sel = -cv;
      default: cos_sel = sv;
    endcase
  endfunction

  logic signed [31:0] c_c, c_c2;
  logic [COEF_W-1:0]  c_bart;
  kind_t              c_kind;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_c    <= cos_sel(s_quad, s_s, s_c);
      c_c2   <= cos_sel(s_quad2, s_s2, s_c2);
      c_bart <= s_bart;
      c_kind <= s_kind;
    end
  end

  // product stage
  logic signed [63:0] p_m1, p_m2, p_c;
  logic [COEF_W-1:0]  p_bart;
  kind_t              p_kind;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_m1   <= 64'(c_c)  * K046;
      p_m2   <= 64'(c_c2) * K008;
      p_c    <= 64'(c_c);
      p_bart <= c_bart;
      p_kind <= c_kind;
    end
  end

  // sum in Q60, round to Q1.15, output register
  logic signed [63:0] r_sum;
  logic [63:0]        r_rnd;
  logic [COEF_W-1:0]  r_coef, coef_next;
  logic [COEF_W-1:0]  coefficient;
  logic               out_of_range;

  always_comb begin
    case (window_type)
      WIN_HANN:    r_sum = (64'sd1 <<< 59) - (p_c <<< 29);
      WIN_HAMMING: r_sum = (K054 <<< 30) - p_m1;
      default:     r_sum = (K042 <<< 30) - (p_c <<< 29) + p_m2;
    endcase
    r_rnd = 64'(r_sum) + (64'd1 << 44);
    if (r_sum <= 0) begin
      r_coef = '0;
    end else if (r_rnd[63:45] > 19'(COEF_ONE)) begin
      r_coef = COEF_ONE;
    end else begin
      r_coef = r_rnd[60:45];
    end

    case (p_kind)
      KIND_RANGE: coef_next = '0;
      KIND_UNIT:  coef_next = COEF_ONE;
      default:    coef_next = (window_type == WIN_BARTLETT) ? p_bart : r_coef;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coefficient  <= coef_next;
      out_of_range <= (p_kind == KIND_RANGE);
    end
  end

  assign out_ch.coefficient  = coefficient;
  assign out_ch.out_of_range = out_of_range;

`ifndef ASSERT_OFF
  a_coef_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.coefficient <= COEF_ONE)
    else $error("coefficient above 1.0");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.out_of_range |-> out_ch.coefficient == '0)
    else $error("out-of-range word with nonzero coefficient");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> vld[0])
    else $error("accepted word lost at pipeline entry");

  // checked only where the last cosine cell holds a live word
  a_cos_bound: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STEPS + 2 + NEST_LAT] |-> t_s[1][NEST_STEPS] <= ONE_Q30)
    else $error("cosine cell output above one");
`endif

endmodule
